// File: sv/bat_pkg.sv
// Shared constants, types and helpers for the buddy allocator tree unit.
`timescale 1ns / 1ps
`default_nettype none
package bat_pkg;
    localparam int unsigned REGION_BYTES    = 131072;
    localparam int unsigned MIN_BLOCK_BYTES = 8;
    localparam int unsigned TOP_ORD   = $clog2(REGION_BYTES);
    localparam int unsigned MIN_ORD   = $clog2(MIN_BLOCK_BYTES);
    localparam int unsigned BIAS      = (MIN_ORD == 0) ? 1 : 0;
    localparam int unsigned LEVELS    = TOP_ORD - MIN_ORD + 1;
    localparam int unsigned NODES     = (1 << LEVELS) - 1;
    localparam int unsigned IDX_W     = LEVELS;
    localparam int unsigned LVL_W     = $clog2(LEVELS);
    localparam int unsigned ORD_W     = 5;
    localparam int unsigned LEAF_FIRST = (1 << (LEVELS - 1)) - 1;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NO_SPACE = 2'd1;
    localparam logic [1:0] STS_RANGE    = 2'd2;
    localparam logic [1:0] STS_NOT_ALLOC = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_ROOT,
        ST_A_DOWN_RD,
        ST_A_DOWN_EV,
        ST_F_RD,
        ST_F_EV,
        ST_MARK,
        ST_UP_RD,
        ST_UP_WR,
        ST_DONE
    } bat_state_t;

    // Order of the smallest block that covers req bytes (may exceed TOP_ORD).
    function automatic logic [ORD_W-1:0] ceil_order(input logic [17:0] req);
        logic [17:0]      m;
        logic [ORD_W-1:0] pos;
        m   = req - 18'd1;
        pos = '0;
        for (int i = 0; i < 18; i++) begin
            if (m[i]) pos = ORD_W'(i);
        end
        if (req <= 18'(MIN_BLOCK_BYTES)) return ORD_W'(MIN_ORD);
        return pos + ORD_W'(1);
    endfunction
endpackage
`default_nettype wire

// File: sv/bat_tree_mem.sv
// Free-order tree storage: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module bat_tree_mem
    import bat_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire logic [ORD_W-1:0] wdata,
    input  wire logic [IDX_W-1:0] raddr_a,
    input  wire logic [IDX_W-1:0] raddr_b,
    output logic      [ORD_W-1:0] rdata_a,
    output logic      [ORD_W-1:0] rdata_b
);
    logic [ORD_W-1:0] ram_reg [0:NODES-1];
    logic [ORD_W-1:0] rdata_a_reg;
    logic [ORD_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_a_reg <= ram_reg[raddr_a];
        rdata_b_reg <= ram_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;
endmodule
`default_nettype wire

// File: sv/buddy_allocator_tree_unit.sv
// Throughput: one request at a time; set by the single tree memory walked per level.
// Each level takes a read state and an evaluate or write-back state.
// After reset a clearing pass writes every node's full order,
// and no request is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none
module buddy_allocator_tree_unit
    import bat_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [17:0] request_size,
    input  wire logic [16:0] target_offset,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic      [1:0]  status,
    output logic      [16:0] block_offset,
    output logic      [17:0] block_bytes
);
    bat_state_t state_reg, state_next;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [ORD_W-1:0] ord_reg, ord_next;
    logic [ORD_W-1:0] k_reg, k_next;
    logic             free_reg, free_next;
    logic             alloc_reg, alloc_next;
    logic [1:0]       sts_reg, sts_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [ORD_W-1:0] res_ord_reg, res_ord_next;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [LVL_W-1:0] clr_lvl_reg;

    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [16:0]      block_offset_reg;
    logic [17:0]      block_bytes_reg;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr_a, raddr_b;
    logic [ORD_W-1:0] wdata, rdata_a, rdata_b;

    logic [IDX_W-1:0] parent, left;
    logic [ORD_W-1:0] k_in, full_val, max_lr;
    logic             accept, out_load, clr_last, clr_lvl_up;
    logic [IDX_W:0]   first_node;
    logic [31:0]      off_wide;

    bat_tree_mem u_mem (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign accept     = req_valid && req_ready;
    assign req_ready  = (state_reg == ST_IDLE);
    assign k_in       = ceil_order(request_size);
    assign parent     = (idx_reg - IDX_W'(1)) >> 1;
    assign left       = {idx_reg[IDX_W-2:0], 1'b1};
    assign full_val   = ord_reg - ORD_W'(1) + ORD_W'(BIAS);
    assign max_lr     = (rdata_a > rdata_b) ? rdata_a : rdata_b;
    assign clr_last   = (clr_idx_reg == IDX_W'(NODES - 1));
    assign clr_lvl_up = ({1'b0, clr_idx_reg} + (IDX_W+1)'(1))
                        == (((IDX_W+1)'(1) << (clr_lvl_reg + LVL_W'(1))) - (IDX_W+1)'(1));
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || rsp_ready);
    assign first_node = ((IDX_W+1)'(1) << (ORD_W'(TOP_ORD) - res_ord_reg)) - (IDX_W+1)'(1);
    assign off_wide   = 32'({1'b0, res_idx_reg} - first_node) << res_ord_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (clr_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_ALLOC)
                        state_next = (k_in > ORD_W'(TOP_ORD)) ? ST_DONE : ST_A_ROOT;
                    else if ({1'b0, target_offset} >= 18'(REGION_BYTES))
                        state_next = ST_DONE;
                    else
                        state_next = ST_F_RD;
                end
            end
            ST_A_ROOT:
            begin
                if (rdata_a < k_reg + ORD_W'(BIAS))  state_next = ST_DONE;
                else if (ord_reg == k_reg)           state_next = ST_MARK;
                else                                 state_next = ST_A_DOWN_RD;
            end
            ST_A_DOWN_RD: state_next = ST_A_DOWN_EV;
            ST_A_DOWN_EV:
                state_next = (ord_reg - ORD_W'(1) == k_reg) ? ST_MARK : ST_A_DOWN_RD;
            ST_F_RD:      state_next = ST_F_EV;
            ST_F_EV:
            begin
                if (rdata_a == '0)            state_next = free_reg ? ST_MARK : ST_DONE;
                else if (idx_reg == '0)       state_next = ST_DONE;
                else                          state_next = ST_F_RD;
            end
            ST_MARK:      state_next = (idx_reg == '0) ? ST_DONE : ST_UP_RD;
            ST_UP_RD:     state_next = ST_UP_WR;
            ST_UP_WR:     state_next = (idx_reg == '0) ? ST_DONE : ST_UP_RD;
            ST_DONE:      if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        idx_next     = idx_reg;
        ord_next     = ord_reg;
        k_next       = k_reg;
        free_next    = free_reg;
        alloc_next   = alloc_reg;
        sts_next     = sts_reg;
        res_idx_next = res_idx_reg;
        res_ord_next = res_ord_reg;
        we           = 1'b0;
        waddr        = idx_reg;
        wdata        = '0;
        raddr_a      = '0;
        raddr_b      = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_idx_reg;
                wdata = ORD_W'(TOP_ORD + BIAS) - ORD_W'(clr_lvl_reg);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    k_next     = k_in;
                    alloc_next = (mode == MODE_ALLOC);
                    free_next  = (mode == MODE_FREE);
                    sts_next   = STS_OK;
                    if (mode == MODE_ALLOC)
                    begin
                        idx_next = '0;
                        ord_next = ORD_W'(TOP_ORD);
                        if (k_in > ORD_W'(TOP_ORD)) sts_next = STS_NO_SPACE;
                    end
                    else
                    begin
                        idx_next = IDX_W'(target_offset >> MIN_ORD) + IDX_W'(LEAF_FIRST);
                        ord_next = ORD_W'(MIN_ORD);
                        if ({1'b0, target_offset} >= 18'(REGION_BYTES)) sts_next = STS_RANGE;
                    end
                end
            end
            ST_A_ROOT:
            begin
                if (rdata_a < k_reg + ORD_W'(BIAS)) sts_next = STS_NO_SPACE;
            end
            ST_A_DOWN_RD: raddr_a = left;
            ST_A_DOWN_EV:
            begin
                idx_next = (rdata_a >= k_reg + ORD_W'(BIAS)) ? left : left + IDX_W'(1);
                ord_next = ord_reg - ORD_W'(1);
            end
            ST_F_RD:      raddr_a = idx_reg;
            ST_F_EV:
            begin
                if (rdata_a == '0)
                begin
                    res_idx_next = idx_reg;
                    res_ord_next = ord_reg;
                end
                else if (idx_reg == '0)
                begin
                    sts_next = STS_NOT_ALLOC;
                end
                else
                begin
                    idx_next = parent;
                    ord_next = ord_reg + ORD_W'(1);
                end
            end
            ST_MARK:
            begin
                we    = 1'b1;
                wdata = alloc_reg ? '0 : ord_reg + ORD_W'(BIAS);
                if (alloc_reg)
                begin
                    res_idx_next = idx_reg;
                    res_ord_next = ord_reg;
                end
                idx_next = parent;
                ord_next = ord_reg + ORD_W'(1);
            end
            ST_UP_RD:
            begin
                raddr_a = left;
                raddr_b = left + IDX_W'(1);
            end
            ST_UP_WR:
            begin
                we = 1'b1;
                // merge the pair back into one block when both halves are wholly free
                if (free_reg && rdata_a == full_val && rdata_b == full_val)
                    wdata = ord_reg + ORD_W'(BIAS);
                else
                    wdata = max_lr;
                idx_next = parent;
                ord_next = ord_reg + ORD_W'(1);
            end
            ST_DONE:      ;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            clr_lvl_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                if (clr_lvl_up) clr_lvl_reg <= clr_lvl_reg + LVL_W'(1);
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        ord_reg     <= ord_next;
        k_reg       <= k_next;
        free_reg    <= free_next;
        alloc_reg   <= alloc_next;
        sts_reg     <= sts_next;
        res_idx_reg <= res_idx_next;
        res_ord_reg <= res_ord_next;
        if (out_load)
        begin
            status_reg <= sts_reg;
            if (sts_reg == STS_OK)
            begin
                block_offset_reg <= off_wide[16:0];
                block_bytes_reg  <= 18'(1) << res_ord_reg;
            end
            else
            begin
                block_offset_reg <= '0;
                block_bytes_reg  <= '0;
            end
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = status_reg;
    assign block_offset = block_offset_reg;
    assign block_bytes  = block_bytes_reg;

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req_ready)
        else $error("request taken during clearing pass");
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_DONE))
        else $error("result shown without a finished walk");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != STS_OK) |-> (block_offset == '0 && block_bytes == '0))
        else $error("error result carries a block");
    a_descent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_DOWN_EV) |-> (ord_reg > k_reg))
        else $error("descent went below the requested order");
endmodule
`default_nettype wire
